// File: sv/mm3_pkg.sv
`default_nettype none

package mm3_pkg;

    localparam int WORD_W  = 32;
    localparam int LANES   = 4;
    localparam int BLOCK_B = 16;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [LANES-1:0] quad_t;
    typedef logic [4:0] rot_t;
    typedef rot_t [LANES-1:0] rot_quad_t;

    localparam word_t MM_C1 = 32'h239b961b;
    localparam word_t MM_C2 = 32'hab0e9789;
    localparam word_t MM_C3 = 32'h38b34ae5;
    localparam word_t MM_C4 = 32'ha1e38b93;
    localparam word_t FM_M1 = 32'h85ebca6b;
    localparam word_t FM_M2 = 32'hc2b2ae35;

    // index 0 sits in the lowest word
    localparam quad_t PRE_MUL_A = {MM_C4, MM_C3, MM_C2, MM_C1};
    localparam quad_t PRE_MUL_B = {MM_C1, MM_C4, MM_C3, MM_C2};
    localparam rot_quad_t PRE_ROT  = {5'd18, 5'd17, 5'd16, 5'd15};
    localparam rot_quad_t LANE_ROT = {5'd13, 5'd15, 5'd17, 5'd19};
    localparam quad_t LANE_ADD = {32'h32ac3b17, 32'h96cd1c35, 32'h0bcaa747, 32'h561ccd1b};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE1,
        ST_PRE2,
        ST_UPD_A,
        ST_UPD_B,
        ST_FIN_X,
        ST_FIN_C,
        ST_FMIX1,
        ST_FMIX2,
        ST_FMIX3,
        ST_FIN_OUT
    } state_t;

    function automatic word_t rotl32(word_t x, rot_t r);
        logic [5:0] rr;
        rr = 6'd32 - {1'b0, r};
        return (x << r) | (x >> rr);
    endfunction

endpackage

`default_nettype wire

// File: sv/mm3_premix.sv
`default_nettype none

module mm3_premix (
    input  wire logic          aclk,
    input  wire mm3_pkg::quad_t k_in,
    output mm3_pkg::quad_t     p_out
);

    mm3_pkg::quad_t s1_reg;
    mm3_pkg::quad_t s2_reg;

    for (genvar i = 0; i < mm3_pkg::LANES; i++) begin : g_lane
        mm3_pkg::word_t rot;

        assign rot = mm3_pkg::rotl32(s1_reg[i], mm3_pkg::PRE_ROT[i]);

        always_ff @(posedge aclk) begin
            s1_reg[i] <= k_in[i] * mm3_pkg::PRE_MUL_A[i];
            s2_reg[i] <= rot * mm3_pkg::PRE_MUL_B[i];
        end
    end

    assign p_out = s2_reg;

endmodule

`default_nettype wire

// File: sv/mm3_fmix.sv
`default_nettype none

module mm3_fmix (
    input  wire logic          aclk,
    input  wire mm3_pkg::quad_t h_in,
    output mm3_pkg::quad_t     f_out
);

    mm3_pkg::quad_t a_reg;
    mm3_pkg::quad_t b_reg;

    for (genvar i = 0; i < mm3_pkg::LANES; i++) begin : g_lane
        mm3_pkg::word_t x0;
        mm3_pkg::word_t x1;

        assign x0 = h_in[i] ^ (h_in[i] >> 16);
        assign x1 = a_reg[i] ^ (a_reg[i] >> 13);

        always_ff @(posedge aclk) begin
            a_reg[i] <= x0 * mm3_pkg::FM_M1;
            b_reg[i] <= x1 * mm3_pkg::FM_M2;
        end

        assign f_out[i] = b_reg[i] ^ (b_reg[i] >> 16);
    end

endmodule

`default_nettype wire

// File: sv/murmur3_128_stream_hash.sv
`default_nettype none

// MurmurHash3 x86 128-bit over a stream of 16-byte blocks. Each block request
// carries four little-endian words, a valid byte count and tlast; the count
// only matters on the last block, where fewer than 16 bytes are hashed as the
// tail. One 128-bit hash comes out per message. A block is taken only in idle,
// after the previous one has passed the accept state, the two multiply stages
// of the four premix lanes, and two lane update steps, since lane 3 needs the
// new lane 0 (a tail block takes one). The last block adds the length fold,
// cross adds and the two-multiply fmix pipeline, and waits in FIN_OUT while
// the output is stalled. The seed is taken at the first block of each message.

module murmur3_128_stream_hash (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data,     // seed
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,      // word0, word1, word2, word3, byte_count[4:0], zero pad
    input  wire logic         s_tlast,      // last
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata       // hash_w0, hash_w1, hash_w2, hash_w3
);

    mm3_pkg::state_t state_reg;
    mm3_pkg::state_t state_next;

    mm3_pkg::word_t seed_reg;
    mm3_pkg::quad_t lane_reg;
    mm3_pkg::quad_t word_reg;
    mm3_pkg::word_t total_reg;
    logic           at_start_reg;
    logic           last_reg;
    logic           full_reg;
    logic           m_valid_reg;
    logic [127:0]   m_data_reg;

    mm3_pkg::quad_t pre;
    mm3_pkg::quad_t fm;
    mm3_pkg::quad_t upd;
    mm3_pkg::quad_t masked;
    mm3_pkg::quad_t xt;
    logic [4:0]     n;
    logic [4:0]     bc;
    logic           s_acc;
    logic           out_load;

    function automatic mm3_pkg::word_t lane_mix(mm3_pkg::word_t h, mm3_pkg::word_t p,
                                                mm3_pkg::word_t nb, mm3_pkg::rot_t r,
                                                mm3_pkg::word_t c);
        mm3_pkg::word_t t;
        t = mm3_pkg::rotl32(h ^ p, r) + nb;
        return (t << 2) + t + c;
    endfunction

    mm3_premix u_premix (
        .aclk  (aclk),
        .k_in  (word_reg),
        .p_out (pre)
    );

    mm3_fmix u_fmix (
        .aclk  (aclk),
        .h_in  (lane_reg),
        .f_out (fm)
    );

    assign bc = s_tdata[132:128];
    assign n  = (!s_tlast || bc > 5'(mm3_pkg::BLOCK_B)) ? 5'(mm3_pkg::BLOCK_B) : bc;

    // bytes at or past the valid count read as zero
    always_comb begin
        for (int b = 0; b < mm3_pkg::BLOCK_B; b++) begin
            masked[b/4][8*(b%4) +: 8] = (5'(b) < n) ? s_tdata[8*b +: 8] : 8'h00;
        end
    end

    assign upd[0] = lane_mix(lane_reg[0], pre[0], lane_reg[1],
                             mm3_pkg::LANE_ROT[0], mm3_pkg::LANE_ADD[0]);
    assign upd[1] = lane_mix(lane_reg[1], pre[1], lane_reg[2],
                             mm3_pkg::LANE_ROT[1], mm3_pkg::LANE_ADD[1]);
    assign upd[2] = lane_mix(lane_reg[2], pre[2], lane_reg[3],
                             mm3_pkg::LANE_ROT[2], mm3_pkg::LANE_ADD[2]);
    assign upd[3] = lane_mix(lane_reg[3], pre[3], lane_reg[0],
                             mm3_pkg::LANE_ROT[3], mm3_pkg::LANE_ADD[3]);

    always_comb begin
        for (int i = 0; i < mm3_pkg::LANES; i++) begin
            xt[i] = lane_reg[i] ^ total_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mm3_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = mm3_pkg::ST_PRE1;
                end
            end
            mm3_pkg::ST_PRE1:  state_next = mm3_pkg::ST_PRE2;
            mm3_pkg::ST_PRE2:  state_next = mm3_pkg::ST_UPD_A;
            mm3_pkg::ST_UPD_A: state_next = full_reg ? mm3_pkg::ST_UPD_B : mm3_pkg::ST_FIN_X;
            mm3_pkg::ST_UPD_B: state_next = last_reg ? mm3_pkg::ST_FIN_X : mm3_pkg::ST_IDLE;
            mm3_pkg::ST_FIN_X: state_next = mm3_pkg::ST_FIN_C;
            mm3_pkg::ST_FIN_C: state_next = mm3_pkg::ST_FMIX1;
            mm3_pkg::ST_FMIX1: state_next = mm3_pkg::ST_FMIX2;
            mm3_pkg::ST_FMIX2: state_next = mm3_pkg::ST_FMIX3;
            mm3_pkg::ST_FMIX3: state_next = mm3_pkg::ST_FIN_OUT;
            mm3_pkg::ST_FIN_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = mm3_pkg::ST_IDLE;
                end
            end
            default: state_next = mm3_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = aresetn && (state_reg == mm3_pkg::ST_IDLE);
        out_load = (state_reg == mm3_pkg::ST_FIN_OUT) && (!m_valid_reg || m_tready);
    end

    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mm3_pkg::ST_IDLE;
            seed_reg     <= '0;
            lane_reg     <= '0;
            total_reg    <= '0;
            at_start_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                seed_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (s_acc) begin
                at_start_reg <= s_tlast;
                total_reg    <= (at_start_reg ? 32'd0 : total_reg) + {27'd0, n};
                if (at_start_reg) begin
                    lane_reg <= {mm3_pkg::LANES{seed_reg}};
                end
            end
            unique case (state_reg)
                mm3_pkg::ST_UPD_A: begin
                    if (full_reg) begin
                        lane_reg[2:0] <= upd[2:0];
                    end else begin
                        for (int i = 0; i < mm3_pkg::LANES; i++) begin
                            lane_reg[i] <= lane_reg[i] ^ pre[i];
                        end
                    end
                end
                mm3_pkg::ST_UPD_B: begin
                    lane_reg[3] <= upd[3];
                end
                mm3_pkg::ST_FIN_X: begin
                    lane_reg[0]   <= xt[0] + xt[1] + xt[2] + xt[3];
                    lane_reg[3:1] <= xt[3:1];
                end
                mm3_pkg::ST_FIN_C: begin
                    for (int i = 1; i < mm3_pkg::LANES; i++) begin
                        lane_reg[i] <= lane_reg[i] + lane_reg[0];
                    end
                end
                mm3_pkg::ST_FMIX3: begin
                    lane_reg[0]   <= fm[0] + fm[1] + fm[2] + fm[3];
                    lane_reg[3:1] <= fm[3:1];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            word_reg <= masked;
            last_reg <= s_tlast;
            full_reg <= (n == 5'(mm3_pkg::BLOCK_B));
        end
        if (out_load) begin
            m_data_reg <= {lane_reg[3] + lane_reg[0], lane_reg[2] + lane_reg[0],
                           lane_reg[1] + lane_reg[0], lane_reg[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

// File: tb/sv/murmur3_128_stream_hash_chk.sv
`timescale 1ns / 100ps

module murmur3_128_stream_hash_chk (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [31:0]  cfg_data,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [135:0] s_tdata,
    input  wire logic         s_tlast,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [127:0] m_tdata,
    output int                mismatch_count,
    output int                hashes_due
);

    localparam logic [127:0] MUL_A = {32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789, 32'h239b961b};
    localparam logic [127:0] MUL_B = {32'h239b961b, 32'ha1e38b93, 32'h38b34ae5, 32'hab0e9789};
    localparam logic [127:0] LANE_ADD_K =
        {32'h32ac3b17, 32'h96cd1c35, 32'h0bcaa747, 32'h561ccd1b};
    localparam mm3_pkg::word_t FMIX_K1 = 32'h85ebca6b;
    localparam mm3_pkg::word_t FMIX_K2 = 32'hc2b2ae35;

    mm3_pkg::word_t seed_r;
    mm3_pkg::quad_t lane_st;
    mm3_pkg::word_t byte_total;
    bit             at_start;
    mm3_pkg::quad_t pending_hashes[$];

    function automatic mm3_pkg::word_t rotl(mm3_pkg::word_t x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic mm3_pkg::word_t premix(mm3_pkg::word_t k, int i);
        mm3_pkg::word_t t;
        t = k * MUL_A[32*i +: 32];
        t = rotl(t, 15 + i);
        return t * MUL_B[32*i +: 32];
    endfunction

    function automatic mm3_pkg::word_t fmix(mm3_pkg::word_t h);
        mm3_pkg::word_t t;
        t = h ^ (h >> 16);
        t = t * FMIX_K1;
        t = t ^ (t >> 13);
        t = t * FMIX_K2;
        return t ^ (t >> 16);
    endfunction

    task automatic add_lanes_across;
        lane_st[0] = lane_st[0] + lane_st[1] + lane_st[2] + lane_st[3];
        for (int i = 1; i < mm3_pkg::LANES; i++)
            lane_st[i] = lane_st[i] + lane_st[0];
    endtask

    task automatic absorb_block(input logic [135:0] req, input logic fin,
                                output bit has_hash, output mm3_pkg::quad_t hash);
        mm3_pkg::quad_t words;
        int             n;
        int             v;
        mm3_pkg::word_t k;
        words = req[127:0];
        n = int'(req[132:128]);
        has_hash = 1'b0;
        hash = '0;
        if (n > 16 || !fin)
            n = 16;
        if (at_start) begin
            for (int i = 0; i < mm3_pkg::LANES; i++)
                lane_st[i] = seed_r;
            byte_total = '0;
            at_start = 1'b0;
        end
        if (n == 16) begin
            for (int i = 0; i < mm3_pkg::LANES; i++) begin
                lane_st[i] = lane_st[i] ^ premix(words[i], i);
                lane_st[i] = rotl(lane_st[i], 19 - 2 * i);
                lane_st[i] = lane_st[i] + lane_st[(i + 1) % mm3_pkg::LANES];
                lane_st[i] = lane_st[i] * 32'd5 + LANE_ADD_K[32*i +: 32];
            end
        end else begin
            // partial final block: only the valid bytes are mixed
            for (int i = 0; i < mm3_pkg::LANES; i++) begin
                if (n > 4 * i) begin
                    v = n - 4 * i;
                    if (v > 4)
                        v = 4;
                    k = words[i] & (32'hffffffff >> (32 - 8 * v));
                    lane_st[i] = lane_st[i] ^ premix(k, i);
                end
            end
        end
        byte_total = byte_total + mm3_pkg::word_t'(n);
        if (fin) begin
            for (int i = 0; i < mm3_pkg::LANES; i++)
                lane_st[i] = lane_st[i] ^ byte_total;
            add_lanes_across();
            for (int i = 0; i < mm3_pkg::LANES; i++)
                lane_st[i] = fmix(lane_st[i]);
            add_lanes_across();
            hash = lane_st;
            has_hash = 1'b1;
            at_start = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        mm3_pkg::quad_t exp_h;
        mm3_pkg::quad_t got_h;
        mm3_pkg::quad_t new_h;
        bit             has;
        bit             bad;
        if (!aresetn) begin
            seed_r = '0;
            lane_st = '0;
            byte_total = '0;
            at_start = 1'b1;
            mismatch_count = 0;
            pending_hashes.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                seed_r = cfg_data;
            if (s_tvalid && s_tready) begin
                absorb_block(s_tdata, s_tlast, has, new_h);
                if (has)
                    pending_hashes.push_back(new_h);
            end
            if (m_tvalid && m_tready) begin
                got_h = m_tdata;
                if (pending_hashes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("hash %h %h %h %h with no request pending",
                                 got_h[0], got_h[1], got_h[2], got_h[3]);
                end else begin
                    exp_h = pending_hashes.pop_front();
                    bad = 1'b0;
                    for (int i = 0; i < mm3_pkg::LANES; i++)
                        if (got_h[i] !== exp_h[i])
                            bad = 1'b1;
                    if (bad) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("hash mismatch: expected %h %h %h %h, got %h %h %h %h",
                                     exp_h[0], exp_h[1], exp_h[2], exp_h[3],
                                     got_h[0], got_h[1], got_h[2], got_h[3]);
                    end
                end
            end
        end
        hashes_due <= pending_hashes.size();
    end

endmodule

// File: tb/sv/murmur3_128_stream_hash_tb.sv
`timescale 1ns / 100ps

module murmur3_128_stream_hash_tb;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_BLOCKS = 325;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [31:0]  cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic [135:0] s_tdata   = '0;
    logic         s_tlast   = 1'b0;
    logic         m_tready  = 1'b0;
    wire logic         cfg_ready;
    wire logic         s_tready;
    wire logic         m_tvalid;
    wire logic [127:0] m_tdata;

    int mismatch_count;
    int hashes_due;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int sent_blocks    = 0;
    int tail_counts[7] = '{1, 3, 4, 5, 8, 12, 15};
    int phase_idle[4]  = '{0, 75, 0, 21};
    int phase_stall[4] = '{0, 0, 75, 21};

    murmur3_128_stream_hash u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    murmur3_128_stream_hash_chk u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .hashes_due     (hashes_due)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("murmur3_128_stream_hash_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic mm3_pkg::word_t rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [127:0] rand_block();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    task automatic push_block(input logic [127:0] words, input logic [4:0] cnt,
                              input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cnt, words};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sent_blocks++;
    endtask

    task automatic wait_idle;
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (hashes_due != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input mm3_pkg::word_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message(input int nblk, input logic [4:0] tail);
        // count on a non-final block has no effect, so it roams freely
        for (int k = 0; k < nblk - 1; k++)
            push_block(rand_block(), 5'($urandom_range(31)), 1'b0);
        push_block(rand_block(), tail, 1'b1);
    endtask

    initial begin
        int r;
        int nblk;
        int target;
        logic [4:0] tail;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // empty message, full and partial final blocks, oversize counts, two-block message
        push_block({4{32'hffffffff}}, 5'd0, 1'b1);
        push_block('0, 5'd16, 1'b1);
        push_block({4{32'hffffffff}}, 5'd16, 1'b1);
        foreach (tail_counts[i])
            push_block(rand_block(), 5'(tail_counts[i]), 1'b1);
        push_block(rand_block(), 5'd17, 1'b1);
        push_block({4{32'hffffffff}}, 5'd31, 1'b1);
        push_block(rand_block(), 5'd0, 1'b0);
        push_block(rand_block(), 5'd16, 1'b1);
        wait_idle();
        write_seed('1);
        push_block(rand_block(), 5'd0, 1'b1);
        // new seed in the middle of a message applies to the next one
        push_block(rand_block(), 5'd5, 1'b0);
        wait_idle();
        write_seed(32'h12345678);
        push_block(rand_block(), 5'd9, 1'b1);
        push_block(rand_block(), 5'd16, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_stall[ph];
            case (ph)
                0: write_seed('0);
                1: write_seed('1);
                default: write_seed($urandom);
            endcase
            target = sent_blocks + PHASE_BLOCKS;
            while (sent_blocks < target) begin
                r = $urandom_range(99);
                if (r < 70)
                    nblk = $urandom_range(1, 4);
                else if (r < 95)
                    nblk = $urandom_range(5, 12);
                else
                    nblk = $urandom_range(13, 40);
                if ($urandom_range(9) == 0)
                    tail = 5'($urandom_range(17, 31));
                else
                    tail = 5'($urandom_range(16));
                send_message(nblk, tail);
                if ($urandom_range(19) == 0) begin
                    wait_idle();
                    write_seed(rand_word());
                end
            end
        end

        wait_idle();
        if (mismatch_count == 0 && hashes_due == 0) begin
            $display("murmur3_128_stream_hash_tb passed");
        end else begin
            $display("murmur3_128_stream_hash_tb failed");
        end
        $finish;
    end

endmodule
